[hw/rtl/sarf_pkg.sv]
// ----------------------------------------------------------------------------
// sarf_pkg
// Shared types and constants for the signed ALU with register file.
// ----------------------------------------------------------------------------
`default_nettype none
package sarf_pkg;
   localparam int NumRegs   = 16;
   localparam int DataWidth = 64;
   localparam int RegIdxW   = 4;
   localparam int CntW      = 7;

   typedef enum logic [3:0] {
      OP_LOAD = 4'd0, OP_ADD = 4'd1, OP_SUB = 4'd2, OP_MUL = 4'd3,
      OP_DIV = 4'd4, OP_MOD = 4'd5, OP_FMA = 4'd6, OP_SQRT = 4'd7,
      OP_LOG10 = 4'd8, OP_AND = 4'd9, OP_OR = 4'd10, OP_XOR = 4'd11
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_READ, ST_MUL0, ST_MUL1, ST_MUL2, ST_DIV, ST_SQRT, ST_LOG,
      ST_WRITE, ST_FETCH, ST_OUT
   } state_type;

   typedef struct packed {
      logic start;
      logic mul_step;
      logic div_step;
      logic sqrt_step;
      logic log_step;
      logic write;
      logic fetch;
   } cmd_type;

   typedef struct packed {
      logic [3:0] op;
      logic       iter_done;
      logic       fetched;
      logic       clearing;
   } status_type;

   typedef struct packed {
      logic [3:0]  req_type;
      logic [3:0]  dest_reg;
      logic [3:0]  src_a_reg;
      logic [3:0]  src_b_reg;
      logic [63:0] load_value;
   } req_type_t_type;

   typedef struct packed {
      logic [63:0] result_value;
      logic        zero_flag;
      logic        second_flag;
      logic        domain_error;
   } rsp_payload_type;
endpackage
`default_nettype wire

[hw/rtl/sarf_if.sv]
// ----------------------------------------------------------------------------
// sarf_req_if / sarf_rsp_if
// Valid/ready channels for instructions and results.
// ----------------------------------------------------------------------------
`default_nettype none
interface sarf_req_if import sarf_pkg::*; ();
   logic           valid;
   logic           ready;
   req_type_t_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface sarf_rsp_if import sarf_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

[hw/rtl/sarf_ram.sv]
// ----------------------------------------------------------------------------
// sarf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module sarf_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(Depth)-1:0] waddr,
   input  wire logic [Width-1:0]         wdata,
   input  wire logic [$clog2(Depth)-1:0] raddr,
   output logic      [Width-1:0]         rdata
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

[hw/rtl/sarf_ctrl.sv]
// ----------------------------------------------------------------------------
// sarf_ctrl
// Sequencer: steps the datapath through read, execute, write and fetch.
// ----------------------------------------------------------------------------
`default_nettype none
module sarf_ctrl import sarf_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   input  wire status_type status,
   output cmd_type         cmd
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_valid && !status.clearing) state_in = ST_READ;
         ST_READ: begin
            case (op_type'(status.op))
               OP_MUL, OP_FMA:   state_in = ST_MUL0;
               OP_DIV, OP_MOD:   state_in = ST_DIV;
               OP_SQRT:          state_in = ST_SQRT;
               OP_LOG10:         state_in = ST_LOG;
               default:          state_in = ST_WRITE;
            endcase
         end
         ST_MUL0: state_in = ST_MUL1;
         ST_MUL1: state_in = ST_MUL2;
         ST_MUL2: state_in = ST_WRITE;
         ST_DIV:  if (status.iter_done) state_in = ST_WRITE;
         ST_SQRT: if (status.iter_done) state_in = ST_WRITE;
         ST_LOG:  if (status.iter_done) state_in = ST_WRITE;
         ST_WRITE: state_in = ST_FETCH;
         ST_FETCH: if (status.fetched) state_in = ST_OUT;
         ST_OUT:  if (rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = !status.clearing;
            cmd.start = req_valid & !status.clearing;
         end
         ST_MUL0, ST_MUL1, ST_MUL2: cmd.mul_step = 1'b1;
         ST_DIV:   cmd.div_step = 1'b1;
         ST_SQRT:  cmd.sqrt_step = 1'b1;
         ST_LOG:   cmd.log_step = 1'b1;
         ST_WRITE: cmd.write = 1'b1;
         ST_FETCH: cmd.fetch = 1'b1;
         ST_OUT:   rsp_valid = 1'b1;
         default: ;
      endcase
   end
endmodule
`default_nettype wire

[hw/rtl/sarf_dpath.sv]
// ----------------------------------------------------------------------------
// sarf_dpath
// Register file, flags, iterative divider, square root, log10 and multiplier.
// ----------------------------------------------------------------------------
`default_nettype none
module sarf_dpath import sarf_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire req_type_t_type  req,
   input  wire cmd_type         cmd,
   output status_type           status,
   output rsp_payload_type      rsp
);
   localparam int W = DataWidth;

   req_type_t_type   req_ff;
   logic [W-1:0]     a_ff, b_ff, d_ff;
   logic [1:0]       rd_phase_ff;
   logic [W-1:0]     rdata_a, rdata_b, rdata_d;
   logic             zf_ff, sf_ff, derr_ff;
   logic [W-1:0]     res_ff;
   logic             wr_en_ff;
   logic [CntW-1:0]  cnt_ff;
   logic [W-1:0]     rem_ff, quo_ff, mag_a_ff, mag_b_ff;
   logic [W-1:0]     sq_x_ff, sq_res_ff, sq_bit_ff;
   logic [W-1:0]     pw_ff;
   logic             pw_ovf_ff;
   logic [W-1:0]     lg_ff;
   logic [W-1:0]     pp0_ff, pp1_ff, pp2_ff, prod_ff;
   logic             fetched_ff;
   logic [W-1:0]     out_ff;

   // Three read ports built from three copies of the register file.
   logic             rf_we;
   logic [W-1:0]     rf_wdata;
   logic             rf_clr_ff;
   logic [RegIdxW:0] clr_ff;

   assign rf_we    = (cmd.write & wr_en_ff) | rf_clr_ff;
   assign rf_wdata = rf_clr_ff ? '0 : res_ff;

   logic [RegIdxW-1:0] waddr;
   assign waddr = rf_clr_ff ? clr_ff[RegIdxW-1:0] : req_ff.dest_reg;

   sarf_ram #(.Width(W), .Depth(NumRegs)) u_rf_a (
      .clock, .we(rf_we), .waddr, .wdata(rf_wdata),
      .raddr(cmd.start ? req.src_a_reg : req_ff.src_a_reg), .rdata(rdata_a));
   sarf_ram #(.Width(W), .Depth(NumRegs)) u_rf_b (
      .clock, .we(rf_we), .waddr, .wdata(rf_wdata),
      .raddr(cmd.start ? req.src_b_reg : req_ff.src_b_reg), .rdata(rdata_b));
   sarf_ram #(.Width(W), .Depth(NumRegs)) u_rf_d (
      .clock, .we(rf_we), .waddr, .wdata(rf_wdata),
      .raddr(cmd.start ? req.dest_reg : req_ff.dest_reg), .rdata(rdata_d));

   always_ff @(posedge clock) begin
      if (reset) begin
         rf_clr_ff <= 1'b1;
         clr_ff    <= '0;
      end else if (rf_clr_ff) begin
         clr_ff <= clr_ff + 1'b1;
         if (clr_ff == (RegIdxW+1)'(NumRegs - 1)) rf_clr_ff <= 1'b0;
      end
   end

   logic a_neg, b_neg, b_zero;
   assign a_neg  = rdata_a[W-1];
   assign b_neg  = rdata_b[W-1];
   assign b_zero = (rdata_b == '0);

   op_type op;
   assign op = op_type'(req_ff.req_type);

   // multiply: 32x32 partial products
   logic [31:0] al, ah, bl, bh;
   assign al = a_ff[31:0];
   assign ah = a_ff[63:32];
   assign bl = b_ff[31:0];
   assign bh = b_ff[63:32];

   // divider step
   logic [W:0]   dtrial;
   logic [W-1:0] dshift;
   assign dshift = {rem_ff[W-2:0], mag_a_ff[W-1]};
   assign dtrial = {1'b0, dshift} - {1'b0, mag_b_ff};

   // sqrt step
   logic [W-1:0] sq_sum;
   assign sq_sum = sq_res_ff + sq_bit_ff;

   logic [W-1:0] pw_mul;
   logic [W+3:0] pw_wide;
   assign pw_wide = {4'b0, pw_ff} * 4'd10 ;
   assign pw_mul  = pw_wide[W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         zf_ff <= 1'b0;
         sf_ff <= 1'b0;
      end else begin
         if (cmd.write && !derr_ff) begin
            case (op)
               OP_SUB: begin
                  zf_ff <= (res_ff == '0);
                  sf_ff <= $signed(a_ff) < $signed(b_ff);
               end
               OP_DIV, OP_MOD: begin
                  zf_ff <= (res_ff == '0);
                  sf_ff <= (b_ff == '0);
               end
               OP_SQRT, OP_LOG10, OP_AND, OP_OR, OP_XOR: zf_ff <= (res_ff == '0);
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         req_ff      <= req;
         rd_phase_ff <= 2'd1;
         fetched_ff  <= 1'b0;
         derr_ff     <= 1'b0;
         wr_en_ff    <= 1'b0;
         cnt_ff      <= '0;
      end else if (rd_phase_ff == 2'd1) begin
         // operands valid now
         rd_phase_ff <= 2'd0;
         a_ff     <= rdata_a;
         b_ff     <= rdata_b;
         d_ff     <= rdata_d;
         mag_a_ff <= a_neg ? -rdata_a : rdata_a;
         mag_b_ff <= b_neg ? -rdata_b : rdata_b;
         rem_ff   <= '0;
         quo_ff   <= '0;
         sq_x_ff  <= rdata_a;
         sq_res_ff <= '0;
         sq_bit_ff <= W'(1) << (W - 2);
         pw_ff     <= W'(10);
         pw_ovf_ff <= 1'b0;
         lg_ff     <= '0;
         cnt_ff    <= '0;
         case (op)
            OP_LOAD: begin
               res_ff   <= req_ff.load_value;
               wr_en_ff <= 1'b1;
            end
            OP_ADD: begin
               res_ff   <= rdata_a + rdata_b;
               wr_en_ff <= 1'b1;
            end
            OP_SUB: begin
               res_ff   <= rdata_a - rdata_b;
               wr_en_ff <= 1'b1;
            end
            OP_AND: begin
               res_ff   <= rdata_a & rdata_b;
               wr_en_ff <= 1'b1;
            end
            OP_OR: begin
               res_ff   <= rdata_a | rdata_b;
               wr_en_ff <= 1'b1;
            end
            OP_XOR: begin
               res_ff   <= rdata_a ^ rdata_b;
               wr_en_ff <= 1'b1;
            end
            OP_DIV, OP_MOD, OP_MUL, OP_FMA: begin
               res_ff   <= '0;
               wr_en_ff <= 1'b1;
            end
            OP_SQRT: begin
               res_ff   <= '0;
               derr_ff  <= a_neg;
               wr_en_ff <= !a_neg;
            end
            OP_LOG10: begin
               res_ff   <= '0;
               derr_ff  <= a_neg || (rdata_a == '0);
               wr_en_ff <= !(a_neg || (rdata_a == '0));
            end
            default: begin
               res_ff   <= '0;
               wr_en_ff <= 1'b0;
            end
         endcase
      end else begin
         if (cmd.mul_step) begin
            cnt_ff <= cnt_ff + 1'b1;
            case (cnt_ff[1:0])
               2'd0: begin
                  pp0_ff <= al * bl;
                  pp1_ff <= {32'b0, al * bh};
                  pp2_ff <= {32'b0, ah * bl};
               end
               2'd1: prod_ff <= pp0_ff + {pp1_ff[31:0] + pp2_ff[31:0], 32'b0};
               default: res_ff <= (op == OP_FMA) ? d_ff + prod_ff : prod_ff;
            endcase
         end
         if (cmd.div_step && !status.iter_done) begin
            cnt_ff   <= cnt_ff + 1'b1;
            mag_a_ff <= {mag_a_ff[W-2:0], 1'b0};
            if (!dtrial[W]) begin
               rem_ff <= dtrial[W-1:0];
               quo_ff <= {quo_ff[W-2:0], 1'b1};
            end else begin
               rem_ff <= dshift;
               quo_ff <= {quo_ff[W-2:0], 1'b0};
            end
         end
         if (cmd.div_step && status.iter_done) begin
            if (b_ff == '0)          res_ff <= '0;
            else if (op == OP_DIV)   res_ff <= (a_ff[W-1] ^ b_ff[W-1]) ? -quo_ff : quo_ff;
            else                     res_ff <= a_ff[W-1] ? -rem_ff : rem_ff;
         end
         if (cmd.sqrt_step && !status.iter_done) begin
            cnt_ff    <= cnt_ff + 1'b1;
            sq_bit_ff <= sq_bit_ff >> 2;
            if (sq_x_ff >= sq_sum) begin
               sq_x_ff   <= sq_x_ff - sq_sum;
               sq_res_ff <= (sq_res_ff >> 1) + sq_bit_ff;
            end else begin
               sq_res_ff <= sq_res_ff >> 1;
            end
         end
         if (cmd.sqrt_step && status.iter_done) res_ff <= sq_res_ff;
         if (cmd.log_step && !status.iter_done) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (!pw_ovf_ff && pw_ff <= a_ff) begin
               lg_ff <= lg_ff + 1'b1;
               if (pw_wide[W+3:W] != '0) pw_ovf_ff <= 1'b1;
               else                      pw_ff <= pw_mul;
            end else begin
               pw_ovf_ff <= 1'b1;
            end
         end
         if (cmd.log_step && status.iter_done) res_ff <= lg_ff;
         if (cmd.fetch) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff[0]) begin
               fetched_ff <= 1'b1;
               out_ff     <= rdata_d;
            end
         end
         if (cmd.write) cnt_ff <= '0;
      end
   end

   always_comb begin
      status.op = req_ff.req_type;
      status.fetched = fetched_ff;
      status.clearing = rf_clr_ff;
      case (op)
         OP_DIV, OP_MOD: status.iter_done = (cnt_ff == CntW'(W));
         OP_SQRT:        status.iter_done = (cnt_ff == CntW'(W / 2));
         default:        status.iter_done = (cnt_ff == CntW'(20));
      endcase
   end

   assign rsp.result_value = out_ff;
   assign rsp.zero_flag    = zf_ff;
   assign rsp.second_flag  = sf_ff;
   assign rsp.domain_error = derr_ff;
endmodule
`default_nettype wire

[hw/rtl/signed_alu_with_register_file.sv]
// ----------------------------------------------------------------------------
// signed_alu_with_register_file
// Signed 64-bit ALU on a 16-entry register file with zero/second flags.
// ----------------------------------------------------------------------------
// One instruction at a time: an item is accepted only when idle, and the next
// one after the result is taken. Load, add, sub, and/or/xor and unused codes
// are computed at once; mul/fma use a partial-product multiply, log10 a loop
// of compare steps, sqrt a loop of bit steps and div/mod the steps of a
// shift-subtract divider. After reset a pass clears the register file and
// no request is accepted until it ends.
`default_nettype none
module signed_alu_with_register_file import sarf_pkg::*; (
   input wire logic  clock,
   input wire logic  reset,
   sarf_req_if.sink  req,
   sarf_rsp_if.source rsp
);
   cmd_type    cmd;
   status_type status;

   sarf_ctrl u_ctrl (
      .clock, .reset,
      .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .status, .cmd);

   sarf_dpath u_dpath (
      .clock, .reset, .req(req.payload), .cmd, .status, .rsp(rsp.payload));
endmodule
`default_nettype wire

[hw/rtl/sarf_checker.sv]
// ----------------------------------------------------------------------------
// sarf_checker
// Port-level checks for the signed ALU.
// ----------------------------------------------------------------------------
`default_nettype none
module sarf_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready
);
   a_no_accept_while_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("accept during pending result");
   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("result dropped");
   a_no_rsp_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !rsp_valid) else $error("result too early");
endmodule

bind signed_alu_with_register_file sarf_checker u_chk (
   .clock, .reset, .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready));
`default_nettype wire
